@@ hdl/counted_set_linked_list_unit_assert.svh @@
// assertion macros for the counted set unit checker
// no dependencies
`ifndef COUNTED_SET_LINKED_LIST_UNIT_ASSERT_SVH
`define COUNTED_SET_LINKED_LIST_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CSL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/csl_pkg.sv @@
// package for the counted set unit: sizes, field widths and shared types
// no dependencies
package csl_pkg;
    localparam int Locs = 512;
    localparam int MultiMax = 3;
    localparam int IdxW = $clog2(Locs);
    localparam int NodeW = $clog2(Locs + 1);
    localparam int CntW = 8;
    localparam int DeltaW = 5;
    localparam int CntMax = 255;
    localparam int FoundW = $clog2(MultiMax + 1);
    localparam int QDepth = 2;
    localparam logic [NodeW-1:0] NoneIdx = NodeW'(Locs);

    typedef enum logic
    {
        FUNC_ADJUST = 1'b0,
        FUNC_LIST = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t func;
        logic [IdxW-1:0] loc;
        logic signed [DeltaW-1:0] delta;
    } cmd_t;

    typedef struct packed
    {
        logic [CntW-1:0] count;
        logic [NodeW-1:0] entries;
        logic [IdxW-1:0] multi_loc;
        logic multi_valid;
        logic last;
    } res_t;
endpackage

@@ hdl/csl_ram.sv @@
// generic single-port ram with registered read
// no dependencies
module csl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hdl/csl_front.sv @@
// front part: accepts input transfers and queues decoded commands
// depends on csl_pkg
module csl_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [15:0]     s_tdata,
    output logic            q_valid,
    input  logic            q_pop,
    output csl_pkg::cmd_t   q_cmd
);
    localparam int PtrW = $clog2(csl_pkg::QDepth);
    csl_pkg::cmd_t buf_reg [csl_pkg::QDepth];
    logic [PtrW-1:0] wr_reg, rd_reg;
    logic [PtrW:0] fill_reg;
    logic push;
    csl_pkg::cmd_t cmd_in;

    always_comb
    begin
        cmd_in.func = csl_pkg::func_t'(s_tdata[0]);
        cmd_in.loc = s_tdata[csl_pkg::IdxW:1];
        cmd_in.delta = s_tdata[csl_pkg::IdxW+csl_pkg::DeltaW:csl_pkg::IdxW+1];
    end

    assign s_tready = (fill_reg != (PtrW+1)'(csl_pkg::QDepth));
    assign push = s_tvalid && s_tready;
    assign q_valid = (fill_reg != '0);
    assign q_cmd = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            fill_reg <= fill_reg + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
        end
    end
endmodule

@@ hdl/csl_back.sv @@
// back part: node pool, key map and list walk sequencer
// depends on csl_pkg and csl_ram
module csl_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_pop,
    input  csl_pkg::cmd_t   q_cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output csl_pkg::res_t   m_res
);
    localparam int IW = csl_pkg::IdxW;
    localparam int NW = csl_pkg::NodeW;
    localparam int CW = csl_pkg::CntW;

    typedef enum logic [3:0]
    {
        ST_INIT, ST_IDLE, ST_MAPRD, ST_MAPWT, ST_DEC, ST_FREEWT, ST_UNLINKP,
        ST_UNLINKN, ST_WALKRD, ST_WALKWT, ST_WALKEV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [IW:0] init_reg;
    csl_pkg::cmd_t cmd_reg;
    logic [NW-1:0] head_reg, free_reg, held_reg, node_reg, cur_reg;
    logic [NW-1:0] prev_reg, nxt_reg;
    logic [CW-1:0] cnt_reg;
    logic [csl_pkg::FoundW-1:0] found_reg;
    logic [IW:0] steps_reg;
    logic out_valid_reg, out_more_reg;
    csl_pkg::res_t res_reg;

    // ram ports: map {present, node}, next, prev, count, key
    logic map_we, nx_we, pv_we, ct_we, ky_we;
    logic [IW-1:0] map_a, nx_a, pv_a, ct_a, ky_a;
    logic [NW:0] map_wd, map_rd;
    logic [NW-1:0] nx_wd, nx_rd, pv_wd, pv_rd;
    logic [CW-1:0] ct_wd, ct_rd;
    logic [IW-1:0] ky_wd, ky_rd;

    csl_ram #(.Width(NW+1), .Depth(csl_pkg::Locs)) u_map (.clk, .we(map_we), .addr(map_a),
        .wdata(map_wd), .rdata(map_rd));
    csl_ram #(.Width(NW), .Depth(csl_pkg::Locs)) u_next (.clk, .we(nx_we), .addr(nx_a),
        .wdata(nx_wd), .rdata(nx_rd));
    csl_ram #(.Width(NW), .Depth(csl_pkg::Locs)) u_prev (.clk, .we(pv_we), .addr(pv_a),
        .wdata(pv_wd), .rdata(pv_rd));
    csl_ram #(.Width(CW), .Depth(csl_pkg::Locs)) u_count (.clk, .we(ct_we), .addr(ct_a),
        .wdata(ct_wd), .rdata(ct_rd));
    csl_ram #(.Width(IW), .Depth(csl_pkg::Locs)) u_key (.clk, .we(ky_we), .addr(ky_a),
        .wdata(ky_wd), .rdata(ky_rd));

    logic signed [CW+1:0] sum;
    logic [CW-1:0] sat;
    logic out_go, out_load;
    assign sum = $signed({2'b00, ct_rd}) + (CW+2)'(cmd_reg.delta);
    assign sat = (sum > (CW+2)'(csl_pkg::CntMax)) ? CW'(csl_pkg::CntMax) : sum[CW-1:0];

    // a pending found result goes out once the following one is found or the list command finishes
    assign out_go = !out_valid_reg || m_tready;
    assign out_load = out_go
        && ((state_reg == ST_OUT && (cmd_reg.func == csl_pkg::FUNC_ADJUST || !out_more_reg
                                     || found_reg == csl_pkg::FoundW'(csl_pkg::MultiMax)))
            || (state_reg == ST_WALKEV && ct_rd > CW'(1) && found_reg != '0));

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_res = res_reg;

    always_comb
    begin
        map_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; ct_we = 1'b0; ky_we = 1'b0;
        map_a = cmd_reg.loc; nx_a = node_reg[IW-1:0]; pv_a = node_reg[IW-1:0];
        ct_a = node_reg[IW-1:0]; ky_a = node_reg[IW-1:0];
        map_wd = '0; nx_wd = '0; pv_wd = '0; ct_wd = '0; ky_wd = cmd_reg.loc;
        unique case (state_reg)
            ST_INIT:
            begin
                map_we = 1'b1; nx_we = 1'b1; ct_we = 1'b1;
                map_a = init_reg[IW-1:0]; nx_a = init_reg[IW-1:0]; ct_a = init_reg[IW-1:0];
                nx_wd = NW'(init_reg) + 1'b1;
            end
            ST_IDLE: map_a = q_cmd.loc;
            ST_MAPRD: ;
            ST_MAPWT:
            begin
                nx_a = map_rd[IW-1:0]; pv_a = map_rd[IW-1:0]; ct_a = map_rd[IW-1:0];
            end
            ST_DEC:
            begin
                if (sat != '0 && !sum[CW+1])
                begin
                    ct_we = 1'b1; ct_wd = sat;
                end
                else
                begin
                    ct_we = 1'b1; map_we = 1'b1;
                    nx_we = 1'b1; nx_wd = free_reg;
                end
            end
            ST_FREEWT:
            begin
                // new node: map, link at head, key, count
                map_we = 1'b1; map_wd = {1'b1, free_reg};
                nx_a = free_reg[IW-1:0]; nx_we = 1'b1; nx_wd = head_reg;
                pv_a = free_reg[IW-1:0]; pv_we = 1'b1; pv_wd = csl_pkg::NoneIdx;
                ky_a = free_reg[IW-1:0]; ky_we = 1'b1;
                ct_a = free_reg[IW-1:0]; ct_we = 1'b1;
                ct_wd = CW'(cmd_reg.delta);
            end
            ST_UNLINKP:
            begin
                if (prev_reg != csl_pkg::NoneIdx)
                begin
                    nx_a = prev_reg[IW-1:0]; nx_we = 1'b1; nx_wd = nxt_reg;
                end
                if (nxt_reg != csl_pkg::NoneIdx)
                begin
                    pv_a = nxt_reg[IW-1:0]; pv_we = 1'b1; pv_wd = prev_reg;
                end
            end
            ST_UNLINKN:
            begin
                if (head_reg != csl_pkg::NoneIdx)
                begin
                    pv_a = head_reg[IW-1:0]; pv_we = 1'b1; pv_wd = node_reg;
                end
            end
            ST_WALKRD:
            begin
                nx_a = cur_reg[IW-1:0]; ct_a = cur_reg[IW-1:0]; ky_a = cur_reg[IW-1:0];
            end
            ST_WALKWT, ST_WALKEV, ST_OUT:
            begin
                nx_a = cur_reg[IW-1:0]; ct_a = cur_reg[IW-1:0]; ky_a = cur_reg[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            init_reg <= '0;
            head_reg <= csl_pkg::NoneIdx;
            free_reg <= '0;
            held_reg <= '0;
            out_valid_reg <= 1'b0;
            out_more_reg <= 1'b0;
            found_reg <= '0;
            steps_reg <= '0;
            cmd_reg <= '0;
            node_reg <= '0;
            cur_reg <= '0;
            prev_reg <= '0;
            nxt_reg <= '0;
            cnt_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == (IW+1)'(csl_pkg::Locs - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_cmd;
                        cur_reg <= head_reg;
                        found_reg <= '0;
                        steps_reg <= '0;
                        state_reg <= (q_cmd.func == csl_pkg::FUNC_ADJUST) ? ST_MAPRD
                                                                           : ST_WALKRD;
                    end
                end
                ST_MAPRD: state_reg <= ST_MAPWT;
                ST_MAPWT:
                begin
                    if (map_rd[NW])
                    begin
                        node_reg <= map_rd[NW-1:0];
                        state_reg <= ST_DEC;
                    end
                    else if (!cmd_reg.delta[csl_pkg::DeltaW-1] && cmd_reg.delta != '0
                             && free_reg != csl_pkg::NoneIdx)
                    begin
                        state_reg <= ST_FREEWT;
                        node_reg <= free_reg;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DEC:
                begin
                    if (sat != '0 && !sum[CW+1])
                    begin
                        cnt_reg <= sat;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        cnt_reg <= '0;
                        prev_reg <= pv_rd;
                        nxt_reg <= nx_rd;
                        free_reg <= node_reg;
                        held_reg <= held_reg - 1'b1;
                        if (head_reg == node_reg)
                        begin
                            head_reg <= nx_rd;
                        end
                        state_reg <= ST_UNLINKP;
                    end
                end
                ST_FREEWT:
                begin
                    state_reg <= ST_UNLINKN;
                    cnt_reg <= CW'(cmd_reg.delta);
                    held_reg <= held_reg + 1'b1;
                end
                ST_UNLINKN:
                begin
                    // old next of the taken node, read while it was relinked
                    free_reg <= nx_rd;
                    head_reg <= node_reg;
                    state_reg <= ST_OUT;
                end
                ST_UNLINKP: state_reg <= ST_OUT;
                ST_WALKRD:
                begin
                    if (cur_reg == csl_pkg::NoneIdx || steps_reg == (IW+1)'(csl_pkg::Locs))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_WALKWT;
                    end
                end
                ST_WALKWT: state_reg <= ST_WALKEV;
                ST_WALKEV:
                begin
                    if (out_go)
                    begin
                        steps_reg <= steps_reg + 1'b1;
                        cur_reg <= nx_rd;
                        if (ct_rd > CW'(1))
                        begin
                            found_reg <= found_reg + 1'b1;
                            cnt_reg <= ct_rd;
                            prev_reg <= NW'(ky_rd);
                            out_more_reg <= 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_WALKRD;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_go)
                    begin
                        if (cmd_reg.func == csl_pkg::FUNC_ADJUST)
                        begin
                            res_reg <= '{count: cnt_reg, entries: held_reg, multi_loc: '0,
                                         multi_valid: 1'b0, last: 1'b1};
                            state_reg <= ST_IDLE;
                        end
                        else if (out_more_reg)
                        begin
                            // found one; emit when the next is known or walk ends
                            out_more_reg <= 1'b0;
                            res_reg <= '{count: cnt_reg, entries: held_reg,
                                         multi_loc: prev_reg[IW-1:0], multi_valid: 1'b1,
                                         last: (found_reg ==
                                                csl_pkg::FoundW'(csl_pkg::MultiMax))};
                            if (found_reg == csl_pkg::FoundW'(csl_pkg::MultiMax))
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                state_reg <= ST_WALKRD;
                            end
                        end
                        else if (found_reg == '0)
                        begin
                            res_reg <= '{count: '0, entries: held_reg, multi_loc: '0,
                                         multi_valid: 1'b0, last: 1'b1};
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            res_reg.last <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/counted_set_linked_list_unit.sv @@
// counted set unit: a counted set of keys in a linked node pool
// depends on csl_pkg, csl_front, csl_back, csl_ram
//
// slave channel s_* carries commands: func 0 adds delta to the count of
// loc, func 1 lists up to three keys with a count above one, walking the
// list from its head. master channel m_* returns results; m_tlast marks
// the final result of a command.
// an adjust reads the key map, then updates the count of a held key (and on
// zero unlinks and frees its node), takes a free node for a new key and links
// it at the head, or ignores the key, each path set by the chain of dependent
// ram reads and writes on the node pool; the next command is picked up in idle
// after the result. a list reads, waits for and evaluates each visited node,
// passes the result state on each key found and to finish; a found key goes
// out once the next one is found or the walk ends.
// a two-entry command queue sits between front and back; the front keeps
// taking transfers while the back works until the queue is full.
// after reset the back part runs a clearing pass over all 512 locations of the
// key map, count and next-link rams; commands queue but do not start meanwhile.
// when the receiver stalls, the result register holds and the back part
// waits with the next result; the queue then fills and s_tready drops.
module counted_set_linked_list_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // func, loc[8:0], delta[4:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // count[7:0], entries[9:0], multi_loc[8:0], zero pad
    output logic        m_tuser,   // multi_valid
    output logic        m_tlast
);
    logic q_valid, q_pop;
    csl_pkg::cmd_t q_cmd;
    csl_pkg::res_t res;

    csl_front u_front (.clk, .rst_n, .s_tvalid, .s_tready, .s_tdata, .q_valid, .q_pop, .q_cmd);
    csl_back u_back (.clk, .rst_n, .q_valid, .q_pop, .q_cmd, .m_tvalid, .m_tready,
        .m_res(res));

    assign m_tdata = {5'b0, res.multi_loc, res.entries, res.count};
    assign m_tuser = res.multi_valid;
    assign m_tlast = res.last;
endmodule

@@ hdl/csl_checker.sv @@
// port checker for the counted set unit, bound to the top level
// depends on counted_set_linked_list_unit_assert.svh
`include "counted_set_linked_list_unit_assert.svh"
module csl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    `CSL_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result changed while stalled")
    `CSL_ASSERT_IMPL(a_nomulti, clk, rst_n, m_tvalid && !m_tuser, m_tdata[26:18] == 9'd0,
        "multi_loc set without multi_valid")
    `CSL_ASSERT_IMPL(a_entries, clk, rst_n, m_tvalid, m_tdata[17:8] <= 10'd512,
        "entries out of range")
    `CSL_ASSERT_IMPL(a_cnt, clk, rst_n, m_tvalid && m_tuser, m_tdata[7:0] > 8'd1,
        "multi result count not above one")
endmodule

bind counted_set_linked_list_unit csl_checker u_csl_checker (.*);

@@ bench/counted_set_linked_list_unit_test.sv @@
// testbench for counted_set_linked_list_unit: adjust and list commands with random stalls
// depends on csl_pkg and the unit; predicts results with its own node pool model
`timescale 1ns / 1ps

module counted_set_linked_list_unit_test;
    typedef struct packed
    {
        logic [csl_pkg::CntW-1:0] count;
        logic [csl_pkg::NodeW-1:0] entries;
        logic [csl_pkg::IdxW-1:0] multi_loc;
        logic multi_valid;
        logic last;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    counted_set_linked_list_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: node pool with doubly linked in-use list and free list
    bit key_held[csl_pkg::Locs];
    int key_node[csl_pkg::Locs];
    int nxt[csl_pkg::Locs];
    int prv[csl_pkg::Locs];
    int cnt[csl_pkg::Locs];
    int nkey[csl_pkg::Locs];
    int use_head;
    int free_top;
    int held;

    csl_pkg::cmd_t pending_cmds[$];
    outcome_t awaited[$];
    int errors = 0;
    int results_seen = 0;
    int adjusts_sent = 0;
    int lists_sent = 0;
    int multi_seen = 0;
    int hold_off = 0;
    logic rx_hold = 1'b0;
    bit pause_tx = 1'b0;
    int idle_cycles = 0;

    task automatic report(input string what);
        errors++;
        $display("mismatch %0d: %s", errors, what);
    endtask

    function automatic int adjust(input int key, input int d);
        int n;
        int c;
        if (!key_held[key])
        begin
            if (d <= 0 || free_top >= csl_pkg::Locs)
                return 0;
            n = free_top;
            free_top = nxt[n];
            key_held[key] = 1'b1;
            key_node[key] = n;
            prv[n] = csl_pkg::Locs;
            nxt[n] = use_head;
            if (use_head < csl_pkg::Locs)
                prv[use_head] = n;
            use_head = n;
            nkey[n] = key;
            cnt[n] = d > csl_pkg::CntMax ? csl_pkg::CntMax : d;
            held++;
            return cnt[n];
        end
        n = key_node[key];
        c = cnt[n] + d;
        if (c > csl_pkg::CntMax)
            c = csl_pkg::CntMax;
        if (c > 0)
        begin
            cnt[n] = c;
            return c;
        end
        if (prv[n] < csl_pkg::Locs)
            nxt[prv[n]] = nxt[n];
        if (nxt[n] < csl_pkg::Locs)
            prv[nxt[n]] = prv[n];
        if (use_head == n)
            use_head = nxt[n];
        key_held[key] = 1'b0;
        cnt[n] = 0;
        nxt[n] = free_top;
        free_top = n;
        held--;
        return 0;
    endfunction

    task automatic predict(input csl_pkg::cmd_t c);
        outcome_t o;
        int cur;
        int found;
        int fl[csl_pkg::MultiMax];
        int fc[csl_pkg::MultiMax];
        o = '0;
        if (c.func == csl_pkg::FUNC_ADJUST)
        begin
            adjusts_sent++;
            o.count = csl_pkg::CntW'(adjust(int'(c.loc), int'(c.delta)));
            o.entries = csl_pkg::NodeW'(held);
            o.last = 1'b1;
            awaited.push_back(o);
            return;
        end
        lists_sent++;
        cur = use_head;
        found = 0;
        while (cur < csl_pkg::Locs && found < csl_pkg::MultiMax)
        begin
            if (cnt[cur] > 1)
            begin
                fl[found] = nkey[cur];
                fc[found] = cnt[cur];
                found++;
            end
            cur = nxt[cur];
        end
        if (found == 0)
        begin
            o.entries = csl_pkg::NodeW'(held);
            o.last = 1'b1;
            awaited.push_back(o);
        end
        for (int i = 0; i < found; i++)
        begin
            o.count = csl_pkg::CntW'(fc[i]);
            o.entries = csl_pkg::NodeW'(held);
            o.multi_loc = csl_pkg::IdxW'(fl[i]);
            o.multi_valid = 1'b1;
            o.last = (i == found - 1);
            awaited.push_back(o);
        end
    endtask

    function automatic csl_pkg::cmd_t make_cmd(input csl_pkg::func_t f, input int key,
                                               input int d);
        csl_pkg::cmd_t c;
        c.func = f;
        c.loc = csl_pkg::IdxW'(key);
        c.delta = csl_pkg::DeltaW'(d);
        return c;
    endfunction

    // driver
    int tx_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict(pending_cmds.pop_front());
                tx_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 3) == 0)
                    tx_gap = 0;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && !pause_tx)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, pending_cmds[0].delta, pending_cmds[0].loc,
                                pending_cmds[0].func};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            rx_hold <= 1'b1;
        end
        else
            rx_hold <= 1'b0;
    end

    // monitor and receiver stalls
    int rx_gap = 0;
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.count = m_tdata[7:0];
                got.entries = m_tdata[17:8];
                got.multi_loc = m_tdata[26:18];
                got.multi_valid = m_tuser;
                got.last = m_tlast;
                results_seen++;
                if (m_tuser)
                    multi_seen++;
                if (awaited.size() == 0)
                    report("result with nothing expected");
                else
                begin
                    want = awaited.pop_front();
                    if (got.count != want.count)
                        report($sformatf("count %0d, expected %0d", got.count, want.count));
                    if (got.entries != want.entries)
                        report($sformatf("entries %0d, expected %0d",
                                         got.entries, want.entries));
                    if (got.multi_loc != want.multi_loc)
                        report($sformatf("multi_loc %0d, expected %0d",
                                         got.multi_loc, want.multi_loc));
                    if (got.multi_valid != want.multi_valid)
                        report("multi_valid differs");
                    if (got.last != want.last)
                        report("last differs");
                end
                rx_gap = $urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 15);
            end
            if (rx_hold)
                m_tready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else if (++idle_cycles > 20000)
        begin
            $display("timeout with %0d results outstanding", awaited.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int rand_delta();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(1, 8);
        if (r < 9)
            return -int'($urandom_range(0, 8));
        return $urandom_range(0, 1) ? 8 : -8;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || awaited.size() > 0 || s_tvalid)
            @(posedge clk);
    endtask

    initial
    begin
        int key;
        for (int i = 0; i < csl_pkg::Locs; i++)
        begin
            key_held[i] = 1'b0;
            nxt[i] = i + 1;
            cnt[i] = 0;
            prv[i] = 0;
            nkey[i] = 0;
            key_node[i] = 0;
        end
        use_head = csl_pkg::Locs;
        free_top = 0;
        held = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty list, ignored keys, extremes, saturation, removal
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_LIST, 0, 0));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 5, 0));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 5, -8));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 0, 1));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 511, 8));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 170, 7));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 341, 2));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_LIST, 511, -1));
        for (int i = 0; i < 32; i++)
            pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 511, 8));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 0, 1));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_LIST, 0, 0));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 170, -8));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 0, -2));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, 0, 3));
        pending_cmds.push_back(make_cmd(csl_pkg::FUNC_LIST, 0, 0));
        wait_drained();

        // long receiver stall so the queue fills and input backs up
        hold_off = 300;
        for (int i = 0; i < 40; i++)
            pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, $urandom_range(0, 15),
                                            rand_delta()));
        wait_drained();

        // sender pause once all results are back
        pause_tx = 1'b1;
        repeat (20) @(posedge clk);
        pause_tx = 1'b0;

        // random: mostly adjusts on a small key pool, some wide keys, lists between
        for (int i = 0; i < 375; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                pending_cmds.push_back(make_cmd(csl_pkg::FUNC_LIST, $urandom_range(0, 511),
                                                $urandom_range(0, 31)));
            else
            begin
                key = $urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                : $urandom_range(0, 23);
                pending_cmds.push_back(make_cmd(csl_pkg::FUNC_ADJUST, key, rand_delta()));
            end
            if (i == 200)
            begin
                wait_drained();
                pause_tx = 1'b1;
                repeat (30) @(posedge clk);
                pause_tx = 1'b0;
            end
        end
        wait_drained();
        repeat (100) @(posedge clk);

        $display("ran %0d adjusts and %0d lists through stalls and pauses",
                 adjusts_sent, lists_sent);
        $display("checked %0d results, %0d of them multi-count keys",
                 results_seen, multi_seen);
        if (errors == 0 && awaited.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
